// ----- rtl/core/iss_pkg.sv -----
// Shared types and constants for the ignition spark scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package iss_pkg;
    localparam int CYLINDERS   = 8;
    localparam int CYL_W       = 3;
    localparam int MEM_DEPTH   = 2 ** CYL_W;
    localparam int ANG_W       = 15;
    localparam int CFG_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_NUM_W   = 38;
    localparam int DIV_DEN_W   = 24;
    localparam int S_TDATA_W   = 176;
    localparam int M_TDATA_W   = 88;

    localparam logic [CFG_IDX_W-1:0] REG_PREPARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_UP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_DN = 2'd2;

    localparam logic [CFG_W-1:0] SLEW_RESET = 14'd16;

    localparam int FLAG_INIT  = 0;
    localparam int FLAG_SCHED = 1;
    localparam int FLAG_IGN   = 2;
    localparam int FLAG_SLEW  = 3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] slewed;
        logic signed [ANG_W-1:0] dts;
        logic [3:0]              flags;
    } cyl_entry_t;
endpackage
`default_nettype wire

// ----- rtl/core/iss_div.sv -----
// Iterative unsigned divider, two quotient bits per cycle.
// Depends on iss_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none
module iss_div
    import iss_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    localparam int STEPS = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;

    always_comb begin
        logic [DIV_DEN_W:0]   r;
        logic [DIV_NUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++) begin
            r = {r[DIV_DEN_W-1:0], q[DIV_NUM_W-1]};
            q = {q[DIV_NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg}) begin
                r = r - {1'b0, den_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

// ----- rtl/core/ignition_spark_scheduler_unit.sv -----
// A request passes through a slew divide and, on the full timing path, a dwell divide;
// the path is cut short when the prepare window is not reached, without the dwell divide
// and on a clear request, and an out-of-range cylinder skips both; output stalls add.
// One request at a time; the next is taken the cycle after the result is posted.
// A new request may be taken while the previous result still waits on the master side.
// Reset: synchronous, active low; clears all cylinder state through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module ignition_spark_scheduler_unit
    import iss_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // slave: cylinder, requested_advance, trim_advance, crank_position, edge_time,
    // edge_delta, crank_period, time_per_degree, dwell_time, full_cycle,
    // slew_allowed, clear, fire_enable (lowest bit first)
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // master: fire_valid, fire_cylinder, coil_on_time, spark_time,
    // applied_advance (lowest bit first)
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_DIVS  = 4'd3;
    localparam logic [3:0] ST_ADV   = 4'd4;
    localparam logic [3:0] ST_CUR   = 4'd5;
    localparam logic [3:0] ST_DIVD  = 4'd6;
    localparam logic [3:0] ST_COND  = 4'd7;
    localparam logic [3:0] ST_MULH  = 4'd8;
    localparam logic [3:0] ST_MULL  = 4'd9;
    localparam logic [3:0] ST_OFF   = 4'd10;
    localparam logic [3:0] ST_COIL  = 4'd11;
    localparam logic [3:0] ST_WB    = 4'd12;

    logic [3:0] state_reg;

    logic [CFG_W-1:0] prep_reg, slew_up_reg, slew_dn_reg;

    // latched request fields
    logic [CYL_W-1:0]        cyl_reg;
    logic signed [ANG_W-1:0] req_reg, trim_reg, pos_reg;
    logic [31:0]             etime_reg;
    logic [23:0]             delta_reg, period_reg, tpd_reg;
    logic [15:0]             dwell_reg;
    logic                    full_reg, slew_ok_reg, clear_reg, fire_en_reg, oor_reg;

    cyl_entry_t mem [MEM_DEPTH];
    cyl_entry_t rd_data_reg;
    logic [MEM_DEPTH-1:0] vld_reg;
    logic rd_vld_reg;

    logic signed [ANG_W-1:0] old_reg, prev_reg, slewed_reg, adv_reg, cur_reg;
    logic [3:0]              f_reg;
    logic signed [ANG_W:0]   diff_reg;
    logic signed [29:0]      diff2_reg;
    logic [28:0]             mag_reg;
    logic                    neg_reg, fire_reg;
    logic [36:0]             pph_reg;
    logic [39:0]             ppl_reg;
    logic [31:0]             off_reg, coil_reg;

    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;

    logic                    div_start_reg;
    logic [DIV_NUM_W-1:0]    div_num_reg;
    logic [DIV_DEN_W-1:0]    div_den_reg;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign div_req = '{start: div_start_reg, num: div_num_reg, den: div_den_reg};

    iss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    wire s_fire   = s_axis_tvalid && s_axis_tready;
    wire out_free = !out_valid_reg || m_axis_tready;
    wire [CYL_W-1:0] s_cyl = s_axis_tdata[2:0];

    // combinational helpers
    logic signed [ANG_W:0]   adv_sum;
    logic signed [16:0]      dts_full;
    logic signed [ANG_W-1:0] cur_sat;
    logic signed [ANG_W:0]   jump;
    logic                    hold;
    logic [3:0]              f_cur;
    logic [15:0]             diff_mag;
    logic [37:0]             addm;
    logic signed [ANG_W-1:0] slew_new;
    logic signed [30:0]      lead;
    logic [52:0]             psum;

    always_comb begin
        diff_mag = diff_reg[ANG_W] ? 16'(-diff_reg) : 16'(diff_reg);
        addm = (div_rsp.quo > {22'd0, diff_mag}) ? {22'd0, diff_mag} : div_rsp.quo;
        if (f_reg[FLAG_SLEW] && slew_ok_reg) begin
            if (diff_reg[ANG_W])
                slew_new = ANG_W'({old_reg[ANG_W-1], old_reg} - signed'({1'b0, addm[14:0]}));
            else
                slew_new = ANG_W'({old_reg[ANG_W-1], old_reg} + signed'({1'b0, addm[14:0]}));
        end else begin
            slew_new = req_reg;
        end

        adv_sum = {slewed_reg[ANG_W-1], slewed_reg} + {trim_reg[ANG_W-1], trim_reg};

        if (17'(pos_reg) < -17'(adv_reg))
            dts_full = -17'(pos_reg) - 17'(adv_reg);
        else
            dts_full = (full_reg ? 17'sd11520 : 17'sd5760) - 17'(pos_reg) - 17'(adv_reg);
        if (dts_full > 17'sd16383)
            cur_sat = 15'sd16383;
        else if (dts_full < -17'sd16384)
            cur_sat = -15'sd16384;
        else
            cur_sat = dts_full[ANG_W-1:0];
        jump = {cur_sat[ANG_W-1], cur_sat} - {prev_reg[ANG_W-1], prev_reg};
        // hold small forward jumps
        hold = (jump > 0) && (jump < 16'sd2880);

        f_cur = f_reg;
        if (f_reg[FLAG_INIT]) begin
            if (f_reg[FLAG_SCHED] || f_reg[FLAG_IGN]) begin
                if (!hold && (jump > 16'sd1440)) begin
                    if (f_reg[FLAG_SCHED]) begin
                        f_cur[FLAG_IGN]   = 1'b1;
                        f_cur[FLAG_SCHED] = 1'b0;
                    end
                end else begin
                    f_cur[FLAG_IGN] = 1'b0;
                end
            end
        end else begin
            f_cur[FLAG_INIT]  = 1'b1;
            f_cur[FLAG_IGN]   = 1'b1;
            f_cur[FLAG_SCHED] = 1'b0;
        end

        lead = {diff2_reg[29], diff2_reg} - signed'({17'd0, prep_reg});
        psum = {pph_reg, 16'd0} + {13'd0, ppl_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg    <= '0;
            slew_up_reg <= SLEW_RESET;
            slew_dn_reg <= SLEW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PREPARE: prep_reg    <= cfg_data;
                REG_SLEW_UP: slew_up_reg <= cfg_data;
                REG_SLEW_DN: slew_dn_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_fire) begin
                    state_reg <= (4'(s_cyl) >= 4'(CYLINDERS)) ? ST_WB : ST_READ;
                end
                ST_READ: state_reg <= ST_MUL;
                ST_MUL: begin
                    div_start_reg <= 1'b1;
                    state_reg <= ST_DIVS;
                end
                ST_DIVS: if (div_rsp.done) state_reg <= ST_ADV;
                ST_ADV:  state_reg <= clear_reg ? ST_WB : ST_CUR;
                ST_CUR: begin
                    if (f_reg[FLAG_INIT] && !f_reg[FLAG_SCHED] && !f_reg[FLAG_IGN]) begin
                        div_start_reg <= 1'b1;
                        state_reg <= ST_DIVD;
                    end else begin
                        state_reg <= ST_WB;
                    end
                end
                ST_DIVD: if (div_rsp.done) state_reg <= ST_COND;
                ST_COND: state_reg <= lead[30] ? ST_MULH : ST_WB;
                ST_MULH: state_reg <= ST_MULL;
                ST_MULL: state_reg <= ST_OFF;
                ST_OFF:  state_reg <= ST_COIL;
                ST_COIL: state_reg <= ST_WB;
                ST_WB: if (out_free) begin
                    out_valid_reg <= 1'b1;
                    if (!oor_reg) vld_reg[cyl_reg] <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cyl_reg     <= s_cyl;
                req_reg     <= s_axis_tdata[17:3];
                trim_reg    <= s_axis_tdata[32:18];
                pos_reg     <= s_axis_tdata[47:33];
                etime_reg   <= s_axis_tdata[79:48];
                delta_reg   <= s_axis_tdata[103:80];
                period_reg  <= (s_axis_tdata[127:104] == '0) ? 24'd1 : s_axis_tdata[127:104];
                tpd_reg     <= (s_axis_tdata[151:128] == '0) ? 24'd1 : s_axis_tdata[151:128];
                dwell_reg   <= s_axis_tdata[167:152];
                full_reg    <= s_axis_tdata[168];
                slew_ok_reg <= s_axis_tdata[169];
                clear_reg   <= s_axis_tdata[170];
                fire_en_reg <= s_axis_tdata[171];
                oor_reg     <= (4'(s_cyl) >= 4'(CYLINDERS));
                rd_data_reg <= mem[s_cyl];
                rd_vld_reg  <= vld_reg[s_cyl];
                fire_reg    <= 1'b0;
                adv_reg     <= '0;
            end
            ST_READ: begin
                // an entry never written since reset reads as cleared state
                old_reg  <= rd_vld_reg ? rd_data_reg.slewed : '0;
                prev_reg <= rd_vld_reg ? rd_data_reg.dts    : '0;
                f_reg    <= rd_vld_reg ? rd_data_reg.flags  : '0;
                diff_reg <= {req_reg[ANG_W-1], req_reg}
                            - (rd_vld_reg ? {rd_data_reg.slewed[ANG_W-1], rd_data_reg.slewed}
                                          : 16'sd0);
            end
            ST_MUL: begin
                div_num_reg <= 38'(diff_reg > 0 ? slew_up_reg : slew_dn_reg) * 38'(delta_reg);
                div_den_reg <= period_reg;
            end
            ST_DIVS: if (div_rsp.done) begin
                slewed_reg <= slew_new;
                f_reg[FLAG_SLEW] <= 1'b1;
            end
            ST_ADV: begin
                if (adv_sum > 16'sd16383)
                    adv_reg <= 15'sd16383;
                else if (adv_sum < -16'sd16384)
                    adv_reg <= -15'sd16384;
                else
                    adv_reg <= adv_sum[ANG_W-1:0];
                if (clear_reg) begin
                    cur_reg <= '0;
                    f_reg   <= f_reg & 4'b1000;
                end
            end
            ST_CUR: begin
                div_num_reg <= {10'd0, dwell_reg, 12'd0};
                div_den_reg <= tpd_reg;
                cur_reg     <= (f_reg[FLAG_INIT] && hold) ? prev_reg : cur_sat;
                f_reg       <= f_cur;
            end
            ST_DIVD: if (div_rsp.done) begin
                diff2_reg <= 30'(cur_reg) - signed'({2'd0, div_rsp.quo[27:0]});
            end
            ST_COND: begin
                neg_reg <= diff2_reg[29];
                mag_reg <= diff2_reg[29] ? 29'(-diff2_reg) : 29'(diff2_reg);
                if (lead[30]) begin
                    f_reg[FLAG_SCHED] <= 1'b1;
                    fire_reg <= fire_en_reg;
                end
            end
            ST_MULH: pph_reg <= 37'(mag_reg[28:16]) * 37'(tpd_reg);
            ST_MULL: ppl_reg <= 40'(mag_reg[15:0]) * 40'(tpd_reg);
            ST_OFF:  off_reg <= psum[43:12];
            ST_COIL: coil_reg <= neg_reg ? etime_reg - off_reg : etime_reg + off_reg;
            ST_WB: if (out_free) begin
                // fire_reg and adv_reg stay clear for an out-of-range cylinder
                out_data_reg <= {5'd0, adv_reg,
                                 fire_reg ? coil_reg + {16'd0, dwell_reg} : 32'd0,
                                 fire_reg ? coil_reg : 32'd0,
                                 cyl_reg, fire_reg};
                if (!oor_reg) begin
                    mem[cyl_reg] <= '{slewed: slewed_reg, dts: cur_reg, flags: f_reg};
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/iss_checker.sv -----
// Port-level checks for the ignition spark scheduler.
// Depends on iss_pkg; bound to ignition_spark_scheduler_unit below.
`timescale 1ns / 1ps
`default_nettype none
module iss_checker
    import iss_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata
);
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("result or busy after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_fire_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[67:4] == '0)
        else $error("times set without a pulse");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
endmodule

bind ignition_spark_scheduler_unit iss_checker u_iss_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
